[rtl/rcsc_pkg.sv]
// ----------------------------------------------------------------------------
// rcsc_pkg
// shared widths, codes, reset values and helpers of the rgb row and column
// sum checker
// ----------------------------------------------------------------------------
package rcsc_pkg;

    localparam int MAX_COLUMNS_DEF  = 1024;
    localparam int MAX_ROWS_DEF     = 1024;
    localparam int CHANNEL_BITS_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int CHAN_W     = 16;
    localparam int COLIDX_W   = 10;
    localparam int POS_W      = 10;
    localparam int TOTAL_W    = 28;
    localparam int DIM_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd1024;
    localparam logic [CHAN_W-1:0] MAXCH_RST  = 16'd255;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PIXEL = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [OUT_USER_W-1:0] {
        KIND_ROW    = 1'b0,
        KIND_COLUMN = 1'b1
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MAX_CHANNEL  = 2'd2
    } t_cfg_addr;

    typedef struct packed {
        logic             pixel;
        logic             query;
        logic             clear;
        logic             end_row;
        logic             col_ok;
        logic             count_err;
        logic             done;
        logic [POS_W-1:0] position;
    } t_s1_ctl;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

endpackage

[rtl/rgb_row_column_sum_checker_unit.sv]
// ----------------------------------------------------------------------------
// rgb_row_column_sum_checker_unit
// raster rgb pixel stream: row totals at end of row, per-column totals in a
// memory read back by query words, sticky range and pixel count errors
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser func, tdata pixel/column
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser kind, tdata total/status
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_addr, i_cfg_data
//
//  one word per cycle unless a clear pass runs or a result meets a stalled output;
//  a taken word is held in the stage register while the column memory is read at
//  the accept edge, and add, write back and the output register load follow when it moves on
//  after reset and after each clear word the column memory is zeroed, one
//  entry a cycle, with s_axis_tready low until every entry is cleared
//  synchronous active low reset; cfg writes are always taken
//  a stalled output holds one result and one more word in the stage before it
// ----------------------------------------------------------------------------
module rgb_row_column_sum_checker_unit
    import rcsc_pkg::*;
#(
    parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // red, green, blue, column_index, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // position, total, range_error, count_error, frame_done, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WCW   = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int SUM_W = CHANNEL_BITS + 2;

    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [CHAN_W-1:0] r_max_channel;

    logic [CW-1:0]      r_col_pos, n_col_pos;
    logic [RW-1:0]      r_row_pos, n_row_pos;
    logic               r_overrun, n_overrun;
    logic               r_range, n_range;
    logic [TOTAL_W-1:0] r_row_acc;

    logic                    r_s1_valid;
    t_s1_ctl                 r_s1, n_s1;
    logic [CW-1:0]           r_s1_addr;
    logic [CHANNEL_BITS-1:0] r_s1_red, r_s1_green, r_s1_blue;

    logic [TOTAL_W-1:0] mem [MAX_COLUMNS];
    logic [TOTAL_W-1:0] r_rd;
    logic               r_fwd_hit;
    logic [TOTAL_W-1:0] r_fwd_data;
    logic               r_clr_busy;
    logic [CW-1:0]      r_clr_addr;

    logic                  r_out_valid;
    logic [OUT_USER_W-1:0] r_out_kind;
    logic [POS_W-1:0]      r_out_pos;
    logic [TOTAL_W-1:0]    r_out_total;
    logic                  r_out_range;
    logic                  r_out_count;
    logic                  r_out_done;

    logic [31:0]        w_reg32, w_eff32, h_reg32, h_eff32, idx32, row32;
    logic [WCW-1:0]     width_c, col_inc;
    logic [RW-1:0]      height_c;
    logic               accept, done_now, ends_row;
    logic [FUNC_W-1:0]  in_func;
    logic [COLIDX_W-1:0] in_idx;
    logic [CW-1:0]      rd_addr;
    logic               s1_has_result, s1_fire;
    logic [TOTAL_W-1:0] col_old, row_new, col_new, ch_sum28;
    logic [SUM_W-1:0]   ch_sum;
    logic               range_hit;
    logic               we;
    logic [CW-1:0]      wa;
    logic [TOTAL_W-1:0] wd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
            r_max_channel  <= MAXCH_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_MAX_CHANNEL:  r_max_channel  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size, zero taken as 1, width clamped to the store depth and height to MAX_ROWS
    always_comb begin
        w_reg32 = 32'(r_frame_width);
        h_reg32 = 32'(r_frame_height);
        if (w_reg32 == 32'd0) begin
            w_eff32 = 32'd1;
        end else if (w_reg32 > 32'(MAX_COLUMNS)) begin
            w_eff32 = 32'(MAX_COLUMNS);
        end else begin
            w_eff32 = w_reg32;
        end
        if (h_reg32 == 32'd0) begin
            h_eff32 = 32'd1;
        end else if (h_reg32 > 32'(MAX_ROWS)) begin
            h_eff32 = 32'(MAX_ROWS);
        end else begin
            h_eff32 = h_reg32;
        end
        width_c  = w_eff32[WCW-1:0];
        height_c = h_eff32[RW-1:0];
    end

    assign in_func  = s_axis_tuser[FUNC_W-1:0];
    assign in_idx   = s_axis_tdata[57:48];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign done_now = r_row_pos >= height_c;
    assign col_inc  = WCW'(r_col_pos) + WCW'(1);
    assign ends_row = col_inc >= width_c;
    assign idx32    = 32'(in_idx);
    assign row32    = 32'(r_row_pos);

    // position counters and word decode at accept
    always_comb begin
        n_col_pos = r_col_pos;
        n_row_pos = r_row_pos;
        n_overrun = r_overrun;
        n_s1      = '0;
        rd_addr   = r_col_pos;
        case (in_func)
            FUNC_PIXEL: begin
                if (done_now) begin
                    n_overrun = 1'b1;
                end else begin
                    n_s1.pixel    = 1'b1;
                    n_s1.end_row  = ends_row;
                    n_s1.position = row32[POS_W-1:0];
                    if (ends_row) begin
                        n_col_pos = '0;
                        n_row_pos = r_row_pos + RW'(1);
                    end else begin
                        n_col_pos = col_inc[CW-1:0];
                    end
                end
            end
            FUNC_QUERY: begin
                n_s1.query    = 1'b1;
                n_s1.col_ok   = idx32 < 32'(MAX_COLUMNS);
                n_s1.position = in_idx;
                rd_addr       = idx32[CW-1:0];
            end
            FUNC_CLEAR: begin
                n_s1.clear = 1'b1;
                n_col_pos  = '0;
                n_row_pos  = '0;
                n_overrun  = 1'b0;
            end
            default: ;
        endcase
        n_s1.count_err = n_overrun;
        n_s1.done      = n_row_pos >= height_c;
    end

    assign s1_has_result = r_s1.query || (r_s1.pixel && r_s1.end_row);
    assign s1_fire       = r_s1_valid && (!s1_has_result || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_fire);

    assign col_old   = r_fwd_hit ? r_fwd_data : r_rd;
    assign ch_sum    = SUM_W'(r_s1_red) + SUM_W'(r_s1_green) + SUM_W'(r_s1_blue);
    assign ch_sum28  = TOTAL_W'(ch_sum);
    assign row_new   = sat_add(r_row_acc, ch_sum28);
    assign col_new   = sat_add(col_old, ch_sum28);
    assign range_hit = (CHAN_W'(r_s1_red) > r_max_channel)
                    || (CHAN_W'(r_s1_green) > r_max_channel)
                    || (CHAN_W'(r_s1_blue) > r_max_channel);
    assign n_range   = r_range || (r_s1.pixel && range_hit);

    always_comb begin
        if (r_clr_busy) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = '0;
        end else begin
            we = s1_fire && r_s1.pixel;
            wa = r_s1_addr;
            wd = col_new;
        end
    end

    // column store, write port and registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (accept) begin
            r_rd       <= mem[rd_addr];
            r_fwd_hit  <= we && (wa == rd_addr);
            r_fwd_data <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + CW'(1);
            if (r_clr_addr == CW'(MAX_COLUMNS - 1)) begin
                r_clr_busy <= 1'b0;
                r_clr_addr <= '0;
            end
        end else if (accept && n_s1.clear) begin
            r_clr_busy <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_overrun  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col_pos  <= n_col_pos;
                r_row_pos  <= n_row_pos;
                r_overrun  <= n_overrun;
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= n_s1;
            r_s1_addr  <= rd_addr;
            r_s1_red   <= s_axis_tdata[CHANNEL_BITS-1:0];
            r_s1_green <= s_axis_tdata[16 +: CHANNEL_BITS];
            r_s1_blue  <= s_axis_tdata[32 +: CHANNEL_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range   <= 1'b0;
            r_row_acc <= '0;
        end else if (s1_fire) begin
            if (r_s1.clear) begin
                r_range   <= 1'b0;
                r_row_acc <= '0;
            end else if (r_s1.pixel) begin
                r_range   <= n_range;
                r_row_acc <= r_s1.end_row ? '0 : row_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_has_result) begin
            r_out_kind  <= r_s1.query ? KIND_COLUMN : KIND_ROW;
            r_out_pos   <= r_s1.position;
            r_out_total <= r_s1.query ? (r_s1.col_ok ? col_old : '0) : row_new;
            r_out_range <= n_range;
            r_out_count <= r_s1.count_err;
            r_out_done  <= r_s1.done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {7'd0, r_out_done, r_out_count, r_out_range,
                            r_out_total, r_out_pos};

endmodule

[sim/rcsc_projection_checker.sv]
// ----------------------------------------------------------------------------
// rcsc_projection_checker
// watches the pixel, result and register channels of the rgb row and column
// sum checker, keeps its own row sums, column store and sticky flags, and
// compares every result word field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module rcsc_projection_checker
    import rcsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [OUT_USER_W-1:0] i_m_tuser,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] total;
        logic               range_err;
        logic               count_err;
        logic               done;
    } t_total_word;

    logic [TOTAL_W-1:0] column_sums [MAX_COLUMNS_DEF];
    logic [TOTAL_W-1:0] row_sum;
    logic [DIM_W-1:0]   col_pos;
    logic [DIM_W-1:0]   row_pos;
    logic               range_seen;
    logic               overrun_seen;
    logic [DIM_W-1:0]   reg_width;
    logic [DIM_W-1:0]   reg_height;
    logic [CHAN_W-1:0]  reg_max;

    t_total_word expected_totals [$];

    int fail_total    = 0;
    int checked_total = 0;
    int pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;
    assign o_pending    = pending_count;

    function automatic int dim_used(input logic [DIM_W-1:0] v, input int top);
        if (v == '0) return 1;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    function automatic logic [TOTAL_W-1:0] add_clipped(input logic [TOTAL_W-1:0] a,
                                                       input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[TOTAL_W]) return {TOTAL_W{1'b1}};
        return s[TOTAL_W-1:0];
    endfunction

    function automatic logic frame_complete();
        return int'(row_pos) >= dim_used(reg_height, MAX_ROWS_DEF);
    endfunction

    task automatic report_failure(input string msg);
        if (fail_total < PRINT_LIMIT) $display("%0t  %s", $time, msg);
        fail_total++;
    endtask

    task automatic clear_frame();
        foreach (column_sums[i]) column_sums[i] = '0;
        row_sum      = '0;
        col_pos      = '0;
        row_pos      = '0;
        range_seen   = 1'b0;
        overrun_seen = 1'b0;
    endtask

    task automatic push_total(input t_kind k, input logic [POS_W-1:0] p,
                              input logic [TOTAL_W-1:0] t);
        t_total_word w;
        w.kind      = k;
        w.position  = p;
        w.total     = t;
        w.range_err = range_seen;
        w.count_err = overrun_seen;
        w.done      = frame_complete();
        expected_totals.push_back(w);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] a,
                                  input logic [CFG_DATA_W-1:0] d);
        case (a)
            CFG_FRAME_WIDTH:  reg_width  = d[DIM_W-1:0];
            CFG_FRAME_HEIGHT: reg_height = d[DIM_W-1:0];
            CFG_MAX_CHANNEL:  reg_max    = d[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic accumulate_word(input logic [FUNC_W-1:0] f,
                                   input logic [CHAN_W-1:0] r, g, b,
                                   input logic [COLIDX_W-1:0] idx);
        logic [TOTAL_W-1:0] pix_sum;
        logic [POS_W-1:0]   row_done;
        logic [TOTAL_W-1:0] row_total;
        case (f)
            FUNC_PIXEL: begin
                if (frame_complete()) begin
                    overrun_seen = 1'b1;
                end else begin
                    if (r > reg_max || g > reg_max || b > reg_max) range_seen = 1'b1;
                    pix_sum = TOTAL_W'(r) + TOTAL_W'(g) + TOTAL_W'(b);
                    row_sum = add_clipped(row_sum, pix_sum);
                    if (int'(col_pos) < MAX_COLUMNS_DEF)
                        column_sums[col_pos] = add_clipped(column_sums[col_pos], pix_sum);
                    col_pos = col_pos + 1'b1;
                    if (int'(col_pos) >= dim_used(reg_width, MAX_COLUMNS_DEF)) begin
                        row_done  = row_pos[POS_W-1:0];
                        row_total = row_sum;
                        row_sum   = '0;
                        col_pos   = '0;
                        row_pos   = row_pos + 1'b1;
                        push_total(KIND_ROW, row_done, row_total);
                    end
                end
            end
            FUNC_QUERY: push_total(KIND_COLUMN, idx, column_sums[idx]);
            FUNC_CLEAR: clear_frame();
            default: ;
        endcase
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] d,
                                input logic [OUT_USER_W-1:0] u);
        t_total_word want;
        if (expected_totals.size() == 0) begin
            report_failure($sformatf("result word with nothing expected: kind %0d pos %0d total %0d",
                                     u, d[9:0], d[37:10]));
            return;
        end
        want = expected_totals.pop_front();
        checked_total++;
        if (u[0] !== want.kind)
            report_failure($sformatf("kind: got %0d expected %0d", u[0], want.kind));
        if (d[9:0] !== want.position)
            report_failure($sformatf("position: got %0d expected %0d", d[9:0], want.position));
        if (d[37:10] !== want.total)
            report_failure($sformatf("total at position %0d: got %0d expected %0d",
                                     want.position, d[37:10], want.total));
        if (d[38] !== want.range_err)
            report_failure($sformatf("range_error at position %0d: got %0d expected %0d",
                                     want.position, d[38], want.range_err));
        if (d[39] !== want.count_err)
            report_failure($sformatf("count_error at position %0d: got %0d expected %0d",
                                     want.position, d[39], want.count_err));
        if (d[40] !== want.done)
            report_failure($sformatf("frame_done at position %0d: got %0d expected %0d",
                                     want.position, d[40], want.done));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            reg_width  = WIDTH_RST;
            reg_height = HEIGHT_RST;
            reg_max    = MAXCH_RST;
            expected_totals.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata, i_m_tuser);
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_addr, i_cfg_data);
            if (i_s_tvalid && i_s_tready)
                accumulate_word(i_s_tuser, i_s_tdata[15:0], i_s_tdata[31:16],
                                i_s_tdata[47:32], i_s_tdata[57:48]);
        end
        pending_count <= expected_totals.size();
    end

endmodule

[sim/rgb_row_column_sum_checker_unit_tb.sv]
// ----------------------------------------------------------------------------
// rgb_row_column_sum_checker_unit_tb
// drives pixel, query, clear and register words into the row and column sum
// checker with random gaps and output stalls, directed corner frames first,
// then random frames; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module rgb_row_column_sum_checker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rcsc_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 950;
    localparam int DRAIN_CYCLES = 8;
    localparam int JUNK_W       = CFG_DATA_W - DIM_W;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;

    bit steady_sender = 1'b0;
    bit hold_request  = 1'b0;
    int idle_cycles   = 0;
    int n_pixel       = 0;
    int n_query       = 0;
    int n_clear       = 0;
    int n_unused      = 0;
    int n_writes      = 0;
    int n_drains      = 0;

    rgb_row_column_sum_checker_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    rcsc_projection_checker u_sums_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches, and one long hold-off on request
    initial begin
        int  stall_left;
        int  mode_left;
        int  sel;
        bit  steady;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    steady    = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                sel = $urandom_range(0, 99);
                if (!steady && sel < 20) begin
                    stall_left = (sel < 17) ? $urandom_range(0, 2) : $urandom_range(10, 60);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        int sel;
        if (steady_sender) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 88) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int dim_used(input logic [DIM_W-1:0] v, input int top);
        if (v == '0) return 1;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input int short_top);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return DIM_W'($urandom_range(1, short_top));
        if (sel < 78) return DIM_W'($urandom_range(short_top + 1, 32));
        if (sel < 86) return '0;
        if (sel < 92) return DIM_W'($urandom_range(1025, 2047));
        if (sel < 96) return DIM_W'(1024);
        return DIM_W'($urandom_range(33, 300));
    endfunction

    function automatic logic [CHAN_W-1:0] pick_max();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return CHAN_W'(255);
        if (sel < 45) return '1;
        if (sel < 55) return '0;
        if (sel < 65) return CHAN_W'(1);
        return CHAN_W'($urandom);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan(input logic [CHAN_W-1:0] mx);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return CHAN_W'($urandom_range(0, mx));
        if (sel < 85) return CHAN_W'($urandom);
        if (sel < 90) return '0;
        if (sel < 95) return '1;
        return (mx == '1) ? mx : mx + 1'b1;
    endfunction

    function automatic logic [COLIDX_W-1:0] pick_column(input int eff_w);
        if ($urandom_range(0, 9) < 7) return COLIDX_W'($urandom_range(0, eff_w - 1));
        return COLIDX_W'($urandom);
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CHAN_W-1:0] r, g, b,
                             input logic [COLIDX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, idx, b, g, r};
        s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (f)
            FUNC_PIXEL: n_pixel++;
            FUNC_QUERY: n_query++;
            FUNC_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
    endtask

    task automatic send_noise(input logic [FUNC_W-1:0] f, input logic [COLIDX_W-1:0] idx);
        send_word(f, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), idx);
    endtask

    task automatic write_reg(input t_cfg_addr a, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        n_writes++;
    endtask

    // unused upper bits of the size registers get random values
    task automatic set_frame(input logic [DIM_W-1:0] w, h, input logic [CHAN_W-1:0] mx);
        logic [JUNK_W-1:0] junk_w;
        logic [JUNK_W-1:0] junk_h;
        junk_w = JUNK_W'($urandom);
        junk_h = JUNK_W'($urandom);
        write_reg(CFG_FRAME_WIDTH, {junk_w, w});
        write_reg(CFG_FRAME_HEIGHT, {junk_h, h});
        write_reg(CFG_MAX_CHANNEL, mx);
    endtask

    // every expected result back, then a drain wait, then the end of any memory clearing pass
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_drains++;
    endtask

    task automatic run_directed();
        set_frame(11'd4, 11'd2, 16'd255);
        send_word(FUNC_PIXEL, 16'd0, 16'd0, 16'd0, 10'h3FF);
        send_word(FUNC_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0);
        send_word(FUNC_PIXEL, 16'd255, 16'd255, 16'd255, 10'd0);
        send_word(FUNC_PIXEL, 16'd256, 16'd0, 16'd1, 10'd0);
        send_word(FUNC_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0);
        send_word(FUNC_QUERY, 16'd0, 16'd0, 16'd0, 10'h3FF);
        send_word(FUNC_QUERY, 16'd0, 16'd0, 16'd0, 10'd3);
        send_word(FUNC_PIXEL, 16'd1, 16'd2, 16'd3, 10'd0);
        send_word(FUNC_PIXEL, 16'hFFFF, 16'd0, 16'd0, 10'd0);
        send_word(FUNC_PIXEL, 16'd0, 16'hFFFF, 16'd0, 10'd0);
        send_word(FUNC_PIXEL, 16'd0, 16'd0, 16'hFFFF, 10'd0);
        // frame complete, this pixel is an overrun
        send_word(FUNC_PIXEL, 16'd7, 16'd7, 16'd7, 10'd0);
        send_word(FUNC_QUERY, 16'd0, 16'd0, 16'd0, 10'd1);
        send_word(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
        send_word(FUNC_CLEAR, 16'd0, 16'd0, 16'd0, 10'd0);
        send_word(FUNC_QUERY, 16'd0, 16'd0, 16'd0, 10'd1);
        settle();
        // zero sizes act as one pixel frames, zero maximum flags any nonzero channel
        set_frame(11'd0, 11'd0, 16'd0);
        send_word(FUNC_PIXEL, 16'd0, 16'd0, 16'd1, 10'd0);
        send_word(FUNC_PIXEL, 16'd1, 16'd1, 16'd1, 10'd0);
        send_word(FUNC_QUERY, 16'd0, 16'd0, 16'd0, 10'd0);
        settle();
        set_frame(11'd2047, 11'd2047, 16'hFFFF);
        send_word(FUNC_PIXEL, 16'd10, 16'd20, 16'd30, 10'd0);
        send_word(FUNC_PIXEL, 16'hFFFF, 16'd1, 16'd2, 10'd0);
        send_word(FUNC_PIXEL, 16'd5, 16'hFFFF, 16'd9, 10'd0);
        settle();
        // width drops below the current column: next pixel closes the row
        write_reg(CFG_FRAME_WIDTH, 16'd2);
        send_word(FUNC_PIXEL, 16'd100, 16'd200, 16'd300, 10'd0);
        send_word(FUNC_QUERY, 16'd0, 16'd0, 16'd0, 10'd2);
        send_word(FUNC_CLEAR, 16'd0, 16'd0, 16'd0, 10'd0);
    endtask

    task automatic random_frame(input bit hold_output);
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [CHAN_W-1:0] mx;
        int eff_w;
        int n;
        int cap;
        int sel;
        settle();
        w  = hold_output ? DIM_W'(1) : pick_dim(6);
        h  = hold_output ? DIM_W'(64) : pick_dim(4);
        mx = pick_max();
        set_frame(w, h, mx);
        eff_w = dim_used(w, MAX_COLUMNS_DEF);
        steady_sender = hold_output || ($urandom_range(0, 3) == 0);
        if (hold_output) begin
            hold_request = 1'b1;
            n = 40;
        end else begin
            if ($urandom_range(0, 9) < 6) send_noise(FUNC_CLEAR, COLIDX_W'($urandom));
            n   = eff_w * eff_h_free(h) + $urandom_range(0, 2);
            cap = $urandom_range(15, 80);
            if (n > cap) n = cap;
        end
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 84)
                send_word(FUNC_PIXEL, pick_chan(mx), pick_chan(mx), pick_chan(mx),
                          COLIDX_W'($urandom));
            else if (sel < 96)
                send_noise(FUNC_QUERY, pick_column(eff_w));
            else if (sel < 98 || hold_output)
                send_noise(FUNC_UNUSED, COLIDX_W'($urandom));
            else
                send_noise(FUNC_CLEAR, COLIDX_W'($urandom));
        end
    endtask

    function automatic int eff_h_free(input logic [DIM_W-1:0] h);
        return dim_used(h, MAX_ROWS_DEF);
    endfunction

    initial begin
        int frame_no;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        frame_no = 0;
        while (n_pixel + n_query + n_clear < ITEM_TARGET) begin
            random_frame(frame_no == 3);
            frame_no++;
        end
        settle();

        $display("summary: %0d pixel, %0d query, %0d clear, %0d unused-code words",
                 n_pixel, n_query, n_clear, n_unused);
        $display("summary: %0d reg writes, %0d result words compared over %0d frames, %0d drains",
                 n_writes, checked, frame_no, n_drains);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
